// ----- design/sdle_pkg.sv -----
// sdle_pkg: shared types and character codes for the signed decimal line extractor
// depends on nothing; imported by every module of the block but sdle_fifo
`default_nettype none

package sdle_pkg;

  // ascii codes the classifier looks for
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // widths of the result ports
  localparam int unsigned OutMantBits = 32;
  localparam int unsigned OutFracBits = 4;

  typedef enum logic [2:0] {
    TK_EOL,
    TK_SIGN,
    TK_DIGIT,
    TK_DOT,
    TK_OTHER
  } tok_class_e;

  typedef struct packed {
    tok_class_e  cls;
    logic        neg;
    logic [3:0]  digit;
  } token_t;

  typedef struct packed {
    logic                    negative;
    logic [OutMantBits-1:0]  mantissa;
    logic [OutFracBits-1:0]  fraction_digits;
    logic                    overflow;
  } result_t;

endpackage

`default_nettype wire

// ----- design/sdle_fifo.sv -----
// sdle_fifo: two-entry queue with registered storage and occupancy count
// generic width; used for the token queue and the result queue
`default_nettype none

module sdle_fifo #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             valid_o
);

  logic [Width-1:0] mem_q [2];
  logic             wptr_q, wptr_d;
  logic             rptr_q, rptr_d;
  logic [1:0]       count_q, count_d;
  logic             push_ok, pop_ok;

  assign full_o  = count_q[1];
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rptr_q];
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && valid_o;

  always_comb begin
    wptr_d  = push_ok ? ~wptr_q : wptr_q;
    rptr_d  = pop_ok ? ~rptr_q : rptr_q;
    count_d = count_q + {1'b0, push_ok} - {1'b0, pop_ok};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ----- design/sdle_front.sv -----
// sdle_front: classifies one received byte into a token for the back end
// depends on sdle_pkg
`default_nettype none

module sdle_front (
  input  logic [7:0]      rx_byte_i,
  output sdle_pkg::token_t tok_o
);
  import sdle_pkg::*;

  logic [7:0] offset;

  assign offset = rx_byte_i - CHAR_ZERO;

  always_comb begin
    tok_o.neg   = (rx_byte_i == CHAR_MINUS);
    tok_o.digit = offset[3:0];
    if (rx_byte_i == CHAR_LF || rx_byte_i == CHAR_CR) begin
      tok_o.cls = TK_EOL;
    end else if (rx_byte_i == CHAR_PLUS || rx_byte_i == CHAR_MINUS) begin
      tok_o.cls = TK_SIGN;
    end else if (rx_byte_i >= CHAR_ZERO && rx_byte_i <= CHAR_NINE) begin
      tok_o.cls = TK_DIGIT;
    end else if (rx_byte_i == CHAR_DOT) begin
      tok_o.cls = TK_DOT;
    end else begin
      tok_o.cls = TK_OTHER;
    end
  end

endmodule

`default_nettype wire

// ----- design/sdle_back.sv -----
// sdle_back: field state machine, mantissa accumulator and fraction counter
// depends on sdle_pkg; takes tokens from the token queue, feeds the result queue
`default_nettype none

module sdle_back #(
  parameter int unsigned MantissaBits = 32,
  parameter int unsigned FracCountMax = 15
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              tok_valid_i,
  input  sdle_pkg::token_t  tok_i,
  output logic              tok_pop_o,
  input  logic              res_full_i,
  output logic              res_push_o,
  output sdle_pkg::result_t res_o
);
  import sdle_pkg::*;

  localparam int unsigned FracBits = $clog2(FracCountMax + 1);

  logic                    sign_q, sign_d;
  logic                    stopped_q, stopped_d;
  logic                    dot_q, dot_d;
  logic                    digit_seen_q, digit_seen_d;
  logic                    neg_q, neg_d;
  logic [MantissaBits-1:0] acc_q, acc_d;
  logic [FracBits-1:0]     frac_q, frac_d;
  logic                    sat_q, sat_d;

  logic                    consume;
  logic                    open_field;
  logic [MantissaBits+3:0] prod;
  logic [MantissaBits+3:0] acc_wide;
  logic [MantissaBits+31:0] mant_ext;
  logic [FracBits+3:0]     frac_ext;

  // acc * 10 + digit, with four spare bits to spot overflow
  assign acc_wide   = {4'b0000, acc_q};
  assign prod       = (acc_wide << 3) + (acc_wide << 1) + {{MantissaBits{1'b0}}, tok_i.digit};
  assign consume    = tok_valid_i && !res_full_i;
  assign open_field = sign_q && !stopped_q;
  assign tok_pop_o  = consume;

  assign mant_ext = {32'd0, acc_q};
  assign frac_ext = {4'b0000, frac_q};

  always_comb begin
    res_o.negative        = neg_q;
    res_o.mantissa        = mant_ext[OutMantBits-1:0];
    res_o.fraction_digits = frac_ext[OutFracBits-1:0];
    res_o.overflow        = sat_q;
  end

  always_comb begin
    sign_d       = sign_q;
    stopped_d    = stopped_q;
    dot_d        = dot_q;
    digit_seen_d = digit_seen_q;
    neg_d        = neg_q;
    acc_d        = acc_q;
    frac_d       = frac_q;
    sat_d        = sat_q;
    res_push_o   = 1'b0;
    if (consume) begin
      unique case (tok_i.cls)
        TK_EOL: begin
          res_push_o   = sign_q && digit_seen_q;
          sign_d       = 1'b0;
          stopped_d    = 1'b0;
          dot_d        = 1'b0;
          digit_seen_d = 1'b0;
          neg_d        = 1'b0;
          acc_d        = '0;
          frac_d       = '0;
          sat_d        = 1'b0;
        end
        TK_SIGN: begin
          sign_d       = 1'b1;
          stopped_d    = 1'b0;
          dot_d        = 1'b0;
          digit_seen_d = 1'b0;
          neg_d        = tok_i.neg;
          acc_d        = '0;
          frac_d       = '0;
          sat_d        = 1'b0;
        end
        TK_DIGIT: begin
          if (open_field) begin
            digit_seen_d = 1'b1;
            if (dot_q && frac_q >= FracBits'(FracCountMax)) begin
              // fraction count full: digit dropped
              sat_d = 1'b1;
            end else begin
              if (dot_q) begin
                frac_d = frac_q + FracBits'(1);
              end
              if (prod[MantissaBits+3:MantissaBits] != 4'd0) begin
                acc_d = '1;
                sat_d = 1'b1;
              end else begin
                acc_d = prod[MantissaBits-1:0];
              end
            end
          end
        end
        TK_DOT: begin
          if (open_field) begin
            if (dot_q) begin
              stopped_d = 1'b1;
            end else begin
              dot_d = 1'b1;
            end
          end
        end
        TK_OTHER: begin
          if (open_field) begin
            stopped_d = 1'b1;
          end
        end
        default: begin
          stopped_d = stopped_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sign_q       <= 1'b0;
      stopped_q    <= 1'b0;
      dot_q        <= 1'b0;
      digit_seen_q <= 1'b0;
      neg_q        <= 1'b0;
      acc_q        <= '0;
      frac_q       <= '0;
      sat_q        <= 1'b0;
    end else begin
      sign_q       <= sign_d;
      stopped_q    <= stopped_d;
      dot_q        <= dot_d;
      digit_seen_q <= digit_seen_d;
      neg_q        <= neg_d;
      acc_q        <= acc_d;
      frac_q       <= frac_d;
      sat_q        <= sat_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/signed_decimal_line_extractor_core.sv -----
// signed_decimal_line_extractor_core: top level of the signed decimal line extractor
// depends on sdle_pkg, sdle_front, sdle_fifo and sdle_back
//
// usage
// - input channel: drive rx_byte_i with push high; the byte is taken at a
//   rising edge where push is high and full is low
// - result channel: while empty is low the oldest result sits on
//   negative_o, mantissa_o, fraction_digits_o and overflow_o; it is taken
//   at a rising edge where pop is high and empty is low
// - one result per line (CR or LF) whose last sign was followed by a digit;
//   value is +/- mantissa_o / 10^fraction_digits_o
// - throughput: one byte per cycle while full is low; the back end updates
//   its accumulator (one times-ten add) for one token each cycle unless
//   the result queue is full; a line end passes through the token queue
//   and the back end into the result queue before it can be popped
// - a two-entry token queue parts the classifier from the accumulator and a
//   two-entry result queue parts the accumulator from the receiver
// - when the receiver stalls, the result queue fills, the back end holds its
//   tokens, the token queue fills and full rises; nothing is dropped
// - reset clears the field state and both queues: full and empty read as
//   not full and empty right away
`default_nettype none

module signed_decimal_line_extractor_core #(
  parameter int unsigned MANTISSA_BITS  = 32,
  parameter int unsigned FRAC_COUNT_MAX = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input queue side
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  // result queue side
  output logic        empty,
  input  logic        pop,
  output logic        negative_o,
  output logic [31:0] mantissa_o,
  output logic [3:0]  fraction_digits_o,
  output logic        overflow_o
);
  import sdle_pkg::*;

  localparam int unsigned TokBits = $bits(token_t);
  localparam int unsigned ResBits = $bits(result_t);

  token_t  tok_in;      // classified byte
  token_t  tok_head;    // oldest queued token
  logic    tok_valid;
  logic    tok_pop;
  logic    res_full;
  logic    res_push;
  result_t res_in;
  result_t res_head;
  logic    res_valid;

  // classify incoming byte
  sdle_front u_front (
    .rx_byte_i (rx_byte_i),
    .tok_o     (tok_in)
  );

  // token queue between front and back
  sdle_fifo #(
    .Width (TokBits)
  ) u_tok_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (tok_in),
    .full_o  (full),
    .pop_i   (tok_pop),
    .data_o  (tok_head),
    .valid_o (tok_valid)
  );

  // field tracking and accumulation
  sdle_back #(
    .MantissaBits (MANTISSA_BITS),
    .FracCountMax (FRAC_COUNT_MAX)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tok_valid),
    .tok_i       (tok_head),
    .tok_pop_o   (tok_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // result queue toward the receiver
  sdle_fifo #(
    .Width (ResBits)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_head),
    .valid_o (res_valid)
  );

  assign empty             = !res_valid;
  assign negative_o        = res_head.negative;
  assign mantissa_o        = res_head.mantissa;
  assign fraction_digits_o = res_head.fraction_digits;
  assign overflow_o        = res_head.overflow;

`ifndef NO_ASSERTIONS
  // back end never pushes into a full result queue
  a_no_res_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  // a full token queue always offers a token to the back end
  a_full_has_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> tok_valid)
    else $error("token queue full but nothing to pop");

  // a pushed result is visible on the next cycle
  a_result_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |=> !empty)
    else $error("pushed result not visible");

  // tokens are only taken when one is present
  a_pop_needs_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_pop |-> tok_valid)
    else $error("token popped from empty queue");
`endif

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// tb: self-checking testbench for signed_decimal_line_extractor_core
// depends on sdle_pkg and the core; drives byte lines, predicts each result in
// a local field tracker and checks every popped result against it
`default_nettype none

module tb;
  import sdle_pkg::*;

  // field tracker limits, matched to the core's default parameters
  localparam longint unsigned MANT_CEIL  = 64'h0000_0000_FFFF_FFFF;
  localparam int unsigned     FRAC_LIMIT = 15;
  // slack after each phase, once every owed result has been popped
  localparam int              SETTLE_CYCLES = 16;
  localparam int              RANDOM_ITEMS  = 2000;
  localparam int              REPORT_LIMIT  = 10;

  // one directed row: a byte and, where obvious, the result it must close
  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    result_t    res;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 24;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic [7:0]  rx_byte_i = 8'h00;
  wire         full;
  wire         empty;
  wire         negative_o;
  wire  [31:0] mantissa_o;
  wire  [3:0]  fraction_digits_o;
  wire         overflow_o;

  // open field of the current line as the core should track it
  bit              fld_open;
  bit              fld_halted;
  bit              fld_dot;
  bit              fld_digit;
  bit              fld_neg;
  bit              fld_sat;
  longint unsigned fld_mant;
  int unsigned     fld_frac;

  // results still owed by the core, oldest first
  result_t pending_results[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned items_sent = 0;
  int unsigned mismatch_count = 0;
  result_t     popped_res;
  result_t     owed_res;
  string       bad_fields;

  // directed lines: empty line, junk before the sign, sign restart with a
  // second dot, a stray byte ending the digits, and a field with no digit
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{CHAR_LF,    1'b0, '0},
    '{8'h00,      1'b0, '0},
    '{CHAR_MINUS, 1'b0, '0},
    '{"9",        1'b0, '0},
    '{CHAR_DOT,   1'b0, '0},
    '{"5",        1'b0, '0},
    '{CHAR_CR,    1'b1, '{1'b1, 32'd95, 4'd1, 1'b0}},
    '{CHAR_MINUS, 1'b0, '0},
    '{"1",        1'b0, '0},
    '{CHAR_PLUS,  1'b0, '0},
    '{"2",        1'b0, '0},
    '{CHAR_DOT,   1'b0, '0},
    '{"3",        1'b0, '0},
    '{CHAR_DOT,   1'b0, '0},
    '{"4",        1'b0, '0},
    '{CHAR_LF,    1'b1, '{1'b0, 32'd23, 4'd1, 1'b0}},
    '{CHAR_PLUS,  1'b0, '0},
    '{"7",        1'b0, '0},
    '{8'hFF,      1'b0, '0},
    '{"8",        1'b0, '0},
    '{CHAR_CR,    1'b1, '{1'b0, 32'd7, 4'd0, 1'b0}},
    '{CHAR_PLUS,  1'b0, '0},
    '{CHAR_DOT,   1'b0, '0},
    '{CHAR_LF,    1'b0, '0}
  };

  signed_decimal_line_extractor_core u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .rx_byte_i         (rx_byte_i),
    .empty             (empty),
    .pop               (pop),
    .negative_o        (negative_o),
    .mantissa_o        (mantissa_o),
    .fraction_digits_o (fraction_digits_o),
    .overflow_o        (overflow_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // hard stop in case the core stalls for good
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic void clear_field();
    fld_open   = 1'b0;
    fld_halted = 1'b0;
    fld_dot    = 1'b0;
    fld_digit  = 1'b0;
    fld_neg    = 1'b0;
    fld_sat    = 1'b0;
    fld_mant   = 64'd0;
    fld_frac   = 0;
  endfunction

  // advance the field tracker by one byte; returns 1 when a line closes
  // with a result, which is then in res
  function automatic bit track_byte(input logic [7:0] b, output result_t res);
    bit          closed;
    int unsigned d;
    closed = 1'b0;
    res = '0;
    if (b == CHAR_LF || b == CHAR_CR) begin
      // line end: report only if the last field holds a digit
      if (fld_open && fld_digit) begin
        res.negative        = fld_neg;
        res.mantissa        = fld_mant[31:0];
        res.fraction_digits = fld_frac[3:0];
        res.overflow        = fld_sat;
        closed = 1'b1;
      end
      clear_field();
    end else if (b == CHAR_PLUS || b == CHAR_MINUS) begin
      // a new sign drops whatever field came before
      clear_field();
      fld_open = 1'b1;
      fld_neg  = (b == CHAR_MINUS);
    end else if (fld_open && !fld_halted) begin
      if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
        d = 32'(b - CHAR_ZERO);
        fld_digit = 1'b1;
        if (fld_dot && fld_frac >= FRAC_LIMIT) begin
          // fraction too long: digit dropped, value truncated
          fld_sat = 1'b1;
        end else begin
          if (fld_dot) fld_frac++;
          if (fld_mant > (MANT_CEIL - d) / 10) begin
            fld_mant = MANT_CEIL;
            fld_sat  = 1'b1;
          end else begin
            fld_mant = fld_mant * 10 + d;
          end
        end
      end else if (b == CHAR_DOT) begin
        if (fld_dot) fld_halted = 1'b1;
        else fld_dot = 1'b1;
      end else begin
        fld_halted = 1'b1;
      end
    end
    return closed;
  endfunction

  // offer one item, idling at random first, and wait until it is taken
  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input result_t typed_res = '0);
    result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (full);
    // taken at this edge
    items_sent++;
    if (track_byte(b, res) || typed) pending_results.push_back(typed ? typed_res : res);
  endtask

  task automatic send_digits(input int unsigned n);
    repeat (n) send_byte(8'(CHAR_ZERO + $urandom_range(9)));
  endtask

  // any byte that neither ends the line nor opens a field
  function automatic logic [7:0] junk_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == CHAR_LF || b == CHAR_CR || b == CHAR_PLUS || b == CHAR_MINUS);
    return b;
  endfunction

  // mostly well-formed lines with random content, the rest noise
  task automatic send_random_line();
    int unsigned pick;
    string       digits;
    string       noise_set;
    noise_set = "+-.0123456789\r\n";
    pick = $urandom_range(99);
    if (pick < 78) begin
      repeat ($urandom_range(2)) send_byte(junk_byte());
      // sometimes an earlier field that the final sign must discard
      if ($urandom_range(4) == 0) begin
        send_byte($urandom_range(1) ? CHAR_MINUS : CHAR_PLUS);
        send_digits($urandom_range(3));
      end
      send_byte($urandom_range(1) ? CHAR_MINUS : CHAR_PLUS);
      case ($urandom_range(19))
        0: digits = "4294967295";     // largest mantissa that fits
        1: digits = "4294967296";     // one past it
        2: digits = "";
        default: digits = "";
      endcase
      if (digits.len() != 0) begin
        foreach (digits[i]) send_byte(digits[i]);
      end else if ($urandom_range(9) == 0) begin
        send_digits($urandom_range(11, 14));
      end else begin
        send_digits($urandom_range(4));
      end
      if ($urandom_range(9) < 6) begin
        send_byte(CHAR_DOT);
        send_digits(($urandom_range(9) == 0) ? $urandom_range(12, 18) : $urandom_range(4));
      end
      // digits after the valid prefix has ended must not count
      case ($urandom_range(9))
        0: begin
          send_byte(CHAR_DOT);
          send_digits($urandom_range(1, 3));
        end
        1: begin
          send_byte(junk_byte());
          send_digits($urandom_range(1, 3));
        end
        default: ;
      endcase
      send_byte($urandom_range(1) ? CHAR_CR : CHAR_LF);
    end else begin
      repeat ($urandom_range(1, 12)) begin
        if ($urandom_range(1)) send_byte(8'($urandom_range(255)));
        else send_byte(noise_set[$urandom_range(noise_set.len() - 1)]);
      end
    end
  endtask

  task automatic flag_result(input string why, input result_t want, input result_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display({"mismatch (%s): expected neg=%0b mant=%0d frac=%0d ovf=%0b,",
                " got neg=%0b mant=%0d frac=%0d ovf=%0b"},
               why, want.negative, want.mantissa, want.fraction_digits, want.overflow,
               got.negative, got.mantissa, got.fraction_digits, got.overflow);
  endtask

  // result side: check every popped result, then choose whether to pop next
  always @(posedge clk_i) begin
    if (pop && !empty) begin
      popped_res = '{negative_o, mantissa_o, fraction_digits_o, overflow_o};
      if (pending_results.size() == 0) begin
        flag_result("no result pending", '0, popped_res);
      end else begin
        owed_res = pending_results.pop_front();
        bad_fields = "";
        if (popped_res.negative !== owed_res.negative) bad_fields = {bad_fields, " negative"};
        if (popped_res.mantissa !== owed_res.mantissa) bad_fields = {bad_fields, " mantissa"};
        if (popped_res.fraction_digits !== owed_res.fraction_digits)
          bad_fields = {bad_fields, " fraction_digits"};
        if (popped_res.overflow !== owed_res.overflow) bad_fields = {bad_fields, " overflow"};
        if (bad_fields != "") flag_result({"bad", bad_fields}, owed_res, popped_res);
      end
    end
    if (rst_ni) pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    int unsigned random_base;
    clear_field();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed lines under the first idling mix
    send_idle_pct = 14;
    recv_idle_pct = 83;
    foreach (directed_rows[i])
      send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].res);

    // random lines in three phases; between phases the sender holds off
    // until every owed result has been popped
    random_base = items_sent;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 14;
          recv_idle_pct = 83;
        end
        1: begin
          send_idle_pct = 83;
          recv_idle_pct = 14;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      while (items_sent < random_base + (phase + 1) * RANDOM_ITEMS / 3) send_random_line();
      push <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk_i);
      repeat (SETTLE_CYCLES) @(posedge clk_i);
    end

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
